FILE: design/pjr_pkg.sv
// package with constants and types for the periodic jump removal block
`default_nettype none
package pjr_pkg;

	localparam int MAX_SHIFTS = 16;
	localparam int NUM_DIMS = 3;
	localparam int TOP_DIMS = (NUM_DIMS > 3) ? 3 : NUM_DIMS;
	localparam int DIM_W = 2;
	localparam int SHIFT_CNT_W = $clog2(MAX_SHIFTS + 1);
	localparam int COORD_W = 32;
	localparam int DIAG_W = 31;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_BOX_XX = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_YX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_YY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_ZX = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_ZY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_ZZ = 3'd5;

	localparam logic [DIM_W-1:0] DIM_X = 2'd0;
	localparam logic [DIM_W-1:0] DIM_Y = 2'd1;
	localparam logic [DIM_W-1:0] DIM_Z = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_POST = 3'b100
	} state_t;

	typedef logic [COORD_W-1:0] coord_t;

endpackage
`default_nettype wire

FILE: design/periodic_jump_removal.sv
// top level: unwraps one atom across a triclinic periodic box with a shared subtract and compare unit
//
// channel   direction  handshake            payload
// in        input      in_valid / in_ready  pos_x..pos_z, ref_x..ref_z, last_atom
// out       output     out_valid / out_ready out_x..out_z, shift_limit_hit, frame_end
// cfg       input      cfg_we               cfg_index, cfg_data
//
// an atom moves from accept to result register in steps, working its dimensions from the top down to x;
// each step is one pass through the shared displacement subtract and compare unit,
// which also drives the row add/subtract
// the next atom can be accepted in the cycle after the result register loads, also while it waits
// a full result register that is not taken holds the finished atom and stalls the input
// reset returns the sequencer to idle and clears the output valid and the box registers to zero
`default_nettype none
module periodic_jump_removal import pjr_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [COORD_W-1:0]   pos_x,
	input  wire logic [COORD_W-1:0]   pos_y,
	input  wire logic [COORD_W-1:0]   pos_z,
	input  wire logic [COORD_W-1:0]   ref_x,
	input  wire logic [COORD_W-1:0]   ref_y,
	input  wire logic [COORD_W-1:0]   ref_z,
	input  wire logic                 last_atom,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [COORD_W-1:0]        out_x,
	output logic [COORD_W-1:0]        out_y,
	output logic [COORD_W-1:0]        out_z,
	output logic                      shift_limit_hit,
	output logic                      frame_end,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COORD_W-1:0]   cfg_data
);

	state_t state_q;

	logic [DIAG_W-1:0]  box_xx_q;
	logic [COORD_W-1:0] box_yx_q;
	logic [DIAG_W-1:0]  box_yy_q;
	logic [COORD_W-1:0] box_zx_q;
	logic [COORD_W-1:0] box_zy_q;
	logic [DIAG_W-1:0]  box_zz_q;

	coord_t p_q [3];
	coord_t r_q [3];
	logic [DIM_W-1:0]       m_q;
	logic                   dir_sub_q;
	logic [SHIFT_CNT_W-1:0] n_q;
	logic                   hit_q;
	logic                   last_q;

	logic                   out_valid_q;
	coord_t                 out_x_q;
	coord_t                 out_y_q;
	coord_t                 out_z_q;
	logic                   out_hit_q;
	logic                   out_last_q;

	coord_t                 row [3];
	logic [DIAG_W-1:0]      diag;
	logic signed [COORD_W:0] disp;
	logic signed [COORD_W:0] diag_s;
	logic signed [COORD_W:0] ndiag_s;
	logic                   cond_add;
	logic                   cond_sub;
	logic                   shift_en;
	logic                   shift_add;
	logic                   dir_switch;
	logic                   dim_done;
	logic                   hit_now;
	logic                   limit;
	logic                   in_acc;
	logic                   post_load;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign post_load = (state_q == ST_POST) && (!out_valid_q || out_ready);

	// box row and diagonal of the current dimension
	always_comb begin
		row[0] = '0;
		row[1] = '0;
		row[2] = '0;
		diag   = '0;
		case (m_q)
			DIM_X: begin
				row[0] = {1'b0, box_xx_q};
				diag   = box_xx_q;
			end
			DIM_Y: begin
				row[0] = box_yx_q;
				row[1] = {1'b0, box_yy_q};
				diag   = box_yy_q;
			end
			DIM_Z: begin
				row[0] = box_zx_q;
				row[1] = box_zy_q;
				row[2] = {1'b0, box_zz_q};
				diag   = box_zz_q;
			end
			default: begin
				diag = '0;
			end
		endcase
	end

	// shared displacement and compare unit
	assign disp    = $signed({p_q[m_q][COORD_W-1], p_q[m_q]})
	               - $signed({r_q[m_q][COORD_W-1], r_q[m_q]});
	assign diag_s  = $signed({2'b00, diag});
	assign ndiag_s = -diag_s;
	assign cond_add = (disp <= ndiag_s);
	assign cond_sub = (disp > diag_s);
	assign limit    = (n_q == SHIFT_CNT_W'(MAX_SHIFTS));

	always_comb begin
		shift_en   = 1'b0;
		shift_add  = 1'b0;
		dir_switch = 1'b0;
		dim_done   = 1'b0;
		hit_now    = 1'b0;
		if (diag == '0) begin
			dim_done = 1'b1;
		end else if (!dir_sub_q) begin
			if (cond_add) begin
				if (limit) begin
					hit_now = 1'b1;
				end else begin
					shift_en  = 1'b1;
					shift_add = 1'b1;
				end
			end else if (cond_sub) begin
				shift_en   = 1'b1;
				dir_switch = 1'b1;
			end else begin
				dim_done = 1'b1;
			end
		end else begin
			if (cond_sub) begin
				if (limit) begin
					hit_now = 1'b1;
				end else begin
					shift_en = 1'b1;
				end
			end else begin
				dim_done = 1'b1;
			end
		end
	end

	// sequencer, box registers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			box_xx_q    <= '0;
			box_yx_q    <= '0;
			box_yy_q    <= '0;
			box_zx_q    <= '0;
			box_zy_q    <= '0;
			box_zz_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BOX_XX: box_xx_q <= cfg_data[DIAG_W-1:0];
					REG_BOX_YX: box_yx_q <= cfg_data;
					REG_BOX_YY: box_yy_q <= cfg_data[DIAG_W-1:0];
					REG_BOX_ZX: box_zx_q <= cfg_data;
					REG_BOX_ZY: box_zy_q <= cfg_data;
					REG_BOX_ZZ: box_zz_q <= cfg_data[DIAG_W-1:0];
					default: ;
				endcase
			end

			if (post_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (hit_now || (dim_done && (m_q == DIM_X))) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					if (post_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// working position, counters and output payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			p_q[0]    <= pos_x;
			p_q[1]    <= pos_y;
			p_q[2]    <= pos_z;
			r_q[0]    <= ref_x;
			r_q[1]    <= ref_y;
			r_q[2]    <= ref_z;
			m_q       <= DIM_W'(TOP_DIMS - 1);
			dir_sub_q <= 1'b0;
			n_q       <= '0;
			hit_q     <= 1'b0;
			last_q    <= last_atom;
		end else if (state_q == ST_RUN) begin
			if (hit_now) begin
				hit_q <= 1'b1;
			end else if (shift_en) begin
				for (int d = 0; d < 3; d++) begin
					p_q[d] <= shift_add ? (p_q[d] + row[d]) : (p_q[d] - row[d]);
				end
				if (dir_switch) begin
					dir_sub_q <= 1'b1;
					n_q       <= SHIFT_CNT_W'(1);
				end else begin
					n_q <= n_q + SHIFT_CNT_W'(1);
				end
			end else if (dim_done && (m_q != DIM_X)) begin
				m_q       <= m_q - DIM_W'(1);
				dir_sub_q <= 1'b0;
				n_q       <= '0;
			end
		end

		if (post_load) begin
			out_x_q    <= p_q[0];
			out_y_q    <= p_q[1];
			out_z_q    <= p_q[2];
			out_hit_q  <= hit_q;
			out_last_q <= last_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_x           = out_x_q;
	assign out_y           = out_y_q;
	assign out_z           = out_z_q;
	assign shift_limit_hit = out_hit_q;
	assign frame_end       = out_last_q;

endmodule
`default_nettype wire

FILE: design/pjr_checker.sv
// port checker for the periodic jump removal block and its bind
`default_nettype none
module pjr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] out_x,
	input wire logic [31:0] out_y,
	input wire logic [31:0] out_z,
	input wire logic        shift_limit_hit,
	input wire logic        frame_end
);

	// a stalled result stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			$stable({out_x, out_y, out_z, shift_limit_hit, frame_end}))
		else $error("result changed while stalled");

	// one atom at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a second transaction while busy");

	// no result can be posted right after a transaction is taken
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result posted too early");

endmodule

bind periodic_jump_removal pjr_checker u_pjr_checker (.*);
`default_nettype wire
